// ===== rtl/krt_pkg.sv =====
`default_nettype none

package krt_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam logic [3:0] OP_ADD      = 4'd0;
    localparam logic [3:0] OP_FIND     = 4'd1;
    localparam logic [3:0] OP_CAPTURE  = 4'd2;
    localparam logic [3:0] OP_RESTORE  = 4'd3;
    localparam logic [3:0] OP_MODIFY   = 4'd4;
    localparam logic [3:0] OP_STATS    = 4'd5;
    localparam logic [3:0] OP_LIST_VAL = 4'd6;
    localparam logic [3:0] OP_LIST_POS = 4'd7;
    localparam logic [3:0] OP_LIST_ACT = 4'd8;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [3:0] operation;
        logic [7:0] row;
        logic [7:0] col;
        logic [7:0] new_row;
        logic [7:0] new_col;
        logic [2:0] kind_number;
        logic [7:0] color_code;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] rec_row;
        logic [7:0] rec_col;
        logic [2:0] rec_kind;
        logic [7:0] rec_color;
        logic [6:0] rec_value;
        logic       rec_active;
        logic [6:0] total_count;
        logic [6:0] active_count;
        logic [6:0] captured_count;
        logic       last;
    } t_out;

    typedef struct packed {
        logic [7:0] row;
        logic [7:0] col;
        logic [2:0] kind;
        logic [7:0] color;
        logic [6:0] value;
        logic       active;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    typedef enum logic [2:0] {
        RES_ADD,
        RES_FULL,
        RES_NOT_FOUND,
        RES_EMPTY,
        RES_REC,
        RES_STATS,
        RES_BEST,
        RES_CUR
    } t_res;

    typedef struct packed {
        logic load;
        logic start;
        logic eval;
        logic count;
        logic add;
        logic modify;
        logic set_res;
        t_res res;
        logic emit;
        logic emit_list;
    } t_cmd;

    typedef struct packed {
        logic [3:0] op;
        logic       full;
        logic       empty;
        logic       scan_done;
        logic       found;
        logic       act_zero;
        logic       cur_active;
        logic       last_item;
        logic       out_free;
    } t_sts;

    function automatic logic [2:0] kind_code(input logic [2:0] k);
        return (k >= 3'd1 && k <= 3'd6) ? k : 3'd0;
    endfunction

    function automatic logic [6:0] kind_value(input logic [2:0] k);
        case (k)
            3'd1:    return 7'd1;
            3'd2:    return 7'd5;
            3'd3:    return 7'd3;
            3'd4:    return 7'd3;
            3'd5:    return 7'd9;
            3'd6:    return 7'd100;
            default: return 7'd0;
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== rtl/krt_ram.sv =====
`default_nettype none

module krt_ram #(
    parameter  int Width = 35,
    parameter  int Depth = 64,
    localparam int AW    = $clog2(Depth)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [Width-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [Width-1:0] o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/krt_ctrl.sv =====
`default_nettype none

module krt_ctrl
    import krt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISP,
        S_RD,
        S_EV,
        S_DONE,
        S_EMIT,
        S_EMIT_L
    } t_state;

    t_state r_state, n_state;
    logic   r_pass, n_pass;

    always_comb begin
        n_state = r_state;
        n_pass  = r_pass;
        o_cmd   = '0;
        o_cmd.res = RES_ADD;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                n_pass = 1'b0;
                case (i_sts.op) inside
                    OP_ADD: begin
                        o_cmd.set_res = 1'b1;
                        if (i_sts.full) begin
                            o_cmd.res = RES_FULL;
                        end else begin
                            o_cmd.add = 1'b1;
                            o_cmd.res = RES_ADD;
                        end
                        n_state = S_EMIT;
                    end
                    OP_FIND, OP_CAPTURE, OP_RESTORE, OP_MODIFY, OP_STATS,
                    OP_LIST_VAL, OP_LIST_POS, OP_LIST_ACT: begin
                        o_cmd.start = 1'b1;
                        n_state     = S_RD;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_RD: begin
                n_state = i_sts.scan_done ? S_DONE : S_EV;
            end
            S_EV: begin
                o_cmd.eval  = 1'b1;
                o_cmd.count = !r_pass;
                if (r_pass && i_sts.cur_active) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res     = RES_CUR;
                    n_state       = S_EMIT_L;
                end else begin
                    n_state = S_RD;
                end
            end
            S_DONE: begin
                o_cmd.set_res = 1'b1;
                n_state       = S_EMIT;
                case (i_sts.op) inside
                    OP_FIND: begin
                        o_cmd.res = i_sts.found ? RES_REC : RES_NOT_FOUND;
                    end
                    OP_CAPTURE, OP_RESTORE, OP_MODIFY: begin
                        o_cmd.modify = i_sts.found;
                        o_cmd.res    = i_sts.found ? RES_REC : RES_NOT_FOUND;
                    end
                    OP_STATS: o_cmd.res = RES_STATS;
                    OP_LIST_VAL, OP_LIST_POS: begin
                        if (i_sts.empty) begin
                            o_cmd.res = RES_EMPTY;
                        end else begin
                            o_cmd.res = RES_BEST;
                            n_state   = S_EMIT_L;
                        end
                    end
                    default: begin
                        if (r_pass) begin
                            o_cmd.set_res = 1'b0;
                            n_state       = S_IDLE;
                        end else if (i_sts.act_zero) begin
                            o_cmd.res = RES_EMPTY;
                        end else begin
                            o_cmd.set_res = 1'b0;
                            o_cmd.start   = 1'b1;
                            n_pass        = 1'b1;
                            n_state       = S_RD;
                        end
                    end
                endcase
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_EMIT_L: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_list = 1'b1;
                    if (i_sts.op == OP_LIST_ACT) begin
                        n_state = S_RD;
                    end else if (i_sts.last_item) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = S_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/krt_dp.sv =====
`default_nettype none

module krt_dp
    import krt_pkg::*;
#(
    parameter int Capacity = CAPACITY_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_in  i_in_data,
    input  wire logic i_out_ready,
    output logic      o_out_valid,
    output t_out      o_out_data,
    input  wire t_cmd i_cmd,
    output t_sts      o_sts
);

    localparam int IW = $clog2(Capacity);
    localparam int CW = $clog2(Capacity + 1);
    localparam int KW = 16 + IW;

    t_in            r_in;
    logic [CW-1:0]  r_cnt, r_idx, r_act, r_emitted;
    logic           r_found, r_have_best, r_have_last;
    logic [IW-1:0]  r_fidx;
    t_rec           r_rec, r_best;
    logic [KW-1:0]  r_best_key, r_last_key;
    t_out           r_res, r_out;
    logic           r_ovalid;

    logic [REC_W-1:0] ram_rdata;
    t_rec             cur, upd, new_rec;
    logic             match, cand, ram_we, out_free;
    logic [KW-1:0]    key_cur;
    logic [IW-1:0]    ram_waddr;
    logic [CW-1:0]    total;
    logic [CW:0]      em1;
    t_out             res;

    krt_ram #(.Width(REC_W), .Depth(Capacity)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_cmd.add ? new_rec : upd),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        cur   = t_rec'(ram_rdata);
        match = (cur.row == r_in.row) && (cur.col == r_in.col);
        if (r_in.operation == OP_LIST_VAL) begin
            key_cur = {9'd0, ~cur.value, r_idx[IW-1:0]};
        end else begin
            key_cur = {cur.row, cur.col, r_idx[IW-1:0]};
        end
        cand = (!r_have_last || key_cur > r_last_key)
            && (!r_have_best || key_cur < r_best_key);

        new_rec.row    = r_in.row;
        new_rec.col    = r_in.col;
        new_rec.kind   = kind_code(r_in.kind_number);
        new_rec.color  = r_in.color_code;
        new_rec.value  = kind_value(r_in.kind_number);
        new_rec.active = 1'b1;

        upd = r_rec;
        case (r_in.operation)
            OP_CAPTURE: upd.active = 1'b0;
            OP_RESTORE: upd.active = 1'b1;
            OP_MODIFY: begin
                upd.row   = r_in.new_row;
                upd.col   = r_in.new_col;
                upd.color = r_in.color_code;
            end
            default: upd = r_rec;
        endcase

        ram_we    = i_cmd.add || i_cmd.modify;
        ram_waddr = i_cmd.add ? r_cnt[IW-1:0] : r_fidx;

        total = (r_in.operation == OP_LIST_ACT) ? r_act : r_cnt;
        em1   = {1'b0, r_emitted} + (CW+1)'(1);

        res = '0;
        res.status = ST_OK;
        res.last   = 1'b1;
        case (i_cmd.res)
            RES_ADD: {res.rec_row, res.rec_col, res.rec_kind, res.rec_color,
                      res.rec_value, res.rec_active} = new_rec;
            RES_FULL:      res.status = ST_FULL;
            RES_NOT_FOUND: res.status = ST_NOT_FOUND;
            RES_EMPTY:     res.status = ST_EMPTY;
            RES_REC: {res.rec_row, res.rec_col, res.rec_kind, res.rec_color,
                      res.rec_value, res.rec_active} = upd;
            RES_STATS: begin
                res.total_count    = 7'(r_cnt);
                res.active_count   = 7'(r_act);
                res.captured_count = 7'(r_cnt - r_act);
            end
            RES_BEST: begin
                {res.rec_row, res.rec_col, res.rec_kind, res.rec_color,
                 res.rec_value, res.rec_active} = r_best;
                res.last = (em1 == {1'b0, total});
            end
            default: begin
                {res.rec_row, res.rec_col, res.rec_kind, res.rec_color,
                 res.rec_value, res.rec_active} = cur;
                res.last = (em1 == {1'b0, total});
            end
        endcase

        out_free = !r_ovalid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in        <= i_in_data;
            r_act       <= '0;
            r_found     <= 1'b0;
            r_emitted   <= '0;
            r_have_last <= 1'b0;
        end
        if (i_cmd.start) begin
            r_idx       <= '0;
            r_have_best <= 1'b0;
        end
        if (i_cmd.eval) begin
            r_idx <= r_idx + CW'(1);
            if (i_cmd.count && cur.active) begin
                r_act <= r_act + CW'(1);
            end
            if (match && !r_found) begin
                r_found <= 1'b1;
                r_fidx  <= r_idx[IW-1:0];
                r_rec   <= cur;
            end
            if (cand) begin
                r_best_key  <= key_cur;
                r_best      <= cur;
                r_have_best <= 1'b1;
            end
        end
        if (i_cmd.set_res) begin
            r_res <= res;
        end
        if (i_cmd.emit_list) begin
            r_emitted   <= r_emitted + CW'(1);
            r_last_key  <= r_best_key;
            r_have_last <= 1'b1;
        end
        if (i_cmd.emit) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.add) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.op         = r_in.operation;
        o_sts.full       = (r_cnt == CW'(Capacity));
        o_sts.empty      = (r_cnt == '0);
        o_sts.scan_done  = (r_idx == r_cnt);
        o_sts.found      = r_found;
        o_sts.act_zero   = (r_act == '0);
        o_sts.cur_active = cur.active;
        o_sts.last_item  = (em1 == {1'b0, total});
        o_sts.out_free   = out_free;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(Capacity))
        else $error("record count beyond capacity");

    a_add_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.add |=> r_cnt == $past(r_cnt) + CW'(1))
        else $error("add did not advance record count");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_out.status != ST_OK |-> r_out.last)
        else $error("error beat without last");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> out_free)
        else $error("beat overwritten while held");

endmodule

`default_nettype wire

// ===== rtl/keyed_record_table.sv =====
// channel | valid      | ready       | payload
// input   | i_in_valid | o_in_ready  | i_in_data  (t_in)
// output  | o_out_valid| i_out_ready | o_out_data (t_out)
//
// add completes without a scan; find, capture, restore, modify and stats scan every
// stored record, one entry at a time through the single read port of the record ram
// sorted listings run one full pass per beat; the active listing counts active records
// in one pass, then emits them in a second pass (an empty status when none are active)
// reset clears the record count and the output valid flag; the ram holds no reset contents
// the input is taken only between operations; a stalled output beat holds the sequencer

`default_nettype none

module keyed_record_table
    import krt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    t_cmd cmd;
    t_sts sts;

    krt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    krt_dp #(.Capacity(CAPACITY)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

`default_nettype wire
